// ----- design/mbq_pkg.sv -----
package mbq_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int CHAN_W      = 6;
    localparam int COEF_W      = 32;
    localparam int CFG_W       = 64;
    localparam int REG_IDX_W   = 3;
    localparam int STAGES      = 3;
    localparam int STAGE_W     = 2;

    // product c*v and its Q.16 form after the rounding shift
    localparam int PROD_W      = COEF_W + SAMPLE_BITS;
    localparam int PROD_SHIFT  = 14;
    localparam int Q_W         = PROD_W - PROD_SHIFT;

    localparam int DLY_W       = 48;
    localparam int YSUM_W      = DLY_W + 1;
    localparam int Y_SHIFT     = 16;
    localparam int YS_W        = YSUM_W - Y_SHIFT;
    localparam int ACC_W       = DLY_W + 1;
    localparam int DIFF_W      = DLY_W + 2;

    localparam logic signed [PROD_W-1:0] PROD_ROUND = PROD_W'(64'sd1 <<< (PROD_SHIFT - 1));
    localparam logic signed [YSUM_W-1:0] Y_ROUND    = YSUM_W'(64'sd1 <<< (Y_SHIFT - 1));
    localparam logic signed [YS_W-1:0]   Y_MAX      =
        YS_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [YS_W-1:0]   Y_MIN      = -Y_MAX - YS_W'(1);

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_ENABLE  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_COUNT   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_HP_B    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_HP_A    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_NOTCH_B = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_NOTCH_A = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_LP_B    = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_LP_A    = 3'd7;

    localparam logic [STAGE_W-1:0] ST_HP    = 2'd0;
    localparam logic [STAGE_W-1:0] ST_NOTCH = 2'd1;
    localparam logic [STAGE_W-1:0] ST_LP    = 2'd2;
    localparam logic [STAGE_W-1:0] ST_DONE  = 2'd3;

    // datapath operations
    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_READ  = 3'd1;
    localparam logic [2:0] OP_YCALC = 3'd2;
    localparam logic [2:0] OP_A1    = 3'd3;
    localparam logic [2:0] OP_A2    = 3'd4;
    localparam logic [2:0] OP_WRITE = 3'd5;
    localparam logic [2:0] OP_EMIT  = 3'd6;

    typedef struct packed {
        logic [CHAN_W-1:0]             chan;
        logic signed [SAMPLE_BITS-1:0] sample_in;
    } t_in_item;

    typedef struct packed {
        logic [CHAN_W-1:0]             chan_out;
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic                          clipped;
    } t_out_item;

    typedef struct packed {
        logic               idle;
        logic [2:0]         op;
        logic [STAGE_W-1:0] stage;
    } t_cmd;

    typedef struct packed {
        logic              active;
        logic [STAGES-1:0] enable;
        logic              out_busy;
    } t_status;

    function automatic logic signed [DLY_W-1:0] sat_dly(input logic signed [DIFF_W-1:0] v);
        logic signed [DLY_W-1:0] r;
        if (v[DIFF_W-1:DLY_W-1] == '0 || v[DIFF_W-1:DLY_W-1] == '1) begin
            r = v[DLY_W-1:0];
        end else if (v[DIFF_W-1]) begin
            r = {1'b1, {(DLY_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(DLY_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

// ----- design/mbq_ram.sv -----
module mbq_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 24,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [AW-1:0]            i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [AW-1:0]            i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- design/mbq_ctrl.sv -----
module mbq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_accept,
    input  mbq_pkg::t_status i_status,
    output mbq_pkg::t_cmd    o_cmd
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_NEXT  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_YCALC = 3'd3;
    localparam logic [2:0] S_A1    = 3'd4;
    localparam logic [2:0] S_A2    = 3'd5;
    localparam logic [2:0] S_WRITE = 3'd6;
    localparam logic [2:0] S_EMIT  = 3'd7;

    logic [2:0]                  r_state, n_state;
    logic [mbq_pkg::STAGE_W-1:0] r_stage, n_stage;
    logic [mbq_pkg::STAGES-1:0]  ge_mask, pending;
    logic [2:0]                  op;

    // sections still to run for this sample, from the current one upward
    always_comb begin
        case (r_stage)
            mbq_pkg::ST_HP:    ge_mask = 3'b111;
            mbq_pkg::ST_NOTCH: ge_mask = 3'b110;
            mbq_pkg::ST_LP:    ge_mask = 3'b100;
            default:           ge_mask = 3'b000;
        endcase
        pending = i_status.enable & ge_mask & {mbq_pkg::STAGES{i_status.active}};
    end

    always_comb begin
        n_state = r_state;
        n_stage = r_stage;
        op      = mbq_pkg::OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_accept) begin
                    n_state = S_NEXT;
                    n_stage = mbq_pkg::ST_HP;
                end
            end
            S_NEXT: begin
                if (pending == '0) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_READ;
                    if (pending[0]) begin
                        n_stage = mbq_pkg::ST_HP;
                    end else if (pending[1]) begin
                        n_stage = mbq_pkg::ST_NOTCH;
                    end else begin
                        n_stage = mbq_pkg::ST_LP;
                    end
                end
            end
            S_READ: begin
                op      = mbq_pkg::OP_READ;
                n_state = S_YCALC;
            end
            S_YCALC: begin
                op      = mbq_pkg::OP_YCALC;
                n_state = S_A1;
            end
            S_A1: begin
                op      = mbq_pkg::OP_A1;
                n_state = S_A2;
            end
            S_A2: begin
                op      = mbq_pkg::OP_A2;
                n_state = S_WRITE;
            end
            S_WRITE: begin
                op      = mbq_pkg::OP_WRITE;
                n_state = S_NEXT;
                n_stage = r_stage + mbq_pkg::STAGE_W'(1);
            end
            S_EMIT: begin
                if (!i_status.out_busy) begin
                    op      = mbq_pkg::OP_EMIT;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_stage <= mbq_pkg::ST_HP;
        end else begin
            r_state <= n_state;
            r_stage <= n_stage;
        end
    end

    assign o_cmd.idle  = (r_state == S_IDLE);
    assign o_cmd.op    = op;
    assign o_cmd.stage = r_stage;
endmodule

// ----- design/mbq_dp.sv -----
module mbq_dp #(
    parameter int MAX_CHANNELS = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mbq_pkg::t_cmd                       i_cmd,
    output mbq_pkg::t_status                    o_status,
    input  logic                                i_in_accept,
    input  mbq_pkg::t_in_item                   i_in_item,
    input  logic                                i_cfg_we,
    input  logic [mbq_pkg::REG_IDX_W-1:0]       i_cfg_index,
    input  logic [mbq_pkg::CFG_W-1:0]           i_cfg_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output mbq_pkg::t_out_item                  o_out_item
);
    localparam int SB    = mbq_pkg::SAMPLE_BITS;
    localparam int DEPTH = MAX_CHANNELS * mbq_pkg::STAGES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CMP_W = mbq_pkg::CHAN_W + 1;
    localparam int DW    = mbq_pkg::DLY_W;

    // configuration
    logic [mbq_pkg::STAGES-1:0] r_enable;
    logic [3:0]                 r_count;
    logic [mbq_pkg::CFG_W-1:0]  r_coef_b [mbq_pkg::STAGES];
    logic [mbq_pkg::CFG_W-1:0]  r_coef_a [mbq_pkg::STAGES];
    logic [mbq_pkg::STAGES-1:0] clr_stages;

    // a delay pair reads as zero until written since the last clear
    logic [mbq_pkg::STAGES-1:0] r_valid [MAX_CHANNELS];

    logic [mbq_pkg::CHAN_W-1:0]     r_chan;
    logic signed [SB-1:0]           r_x, r_y, n_y;
    logic                           r_clip, y_sat;
    logic signed [mbq_pkg::Q_W-1:0] r_prod, r_pb0;
    logic signed [mbq_pkg::ACC_W-1:0] r_acc;
    logic signed [DW-1:0]           r_z1n;
    logic                           r_vld;
    mbq_pkg::t_out_item             r_out;
    logic                           r_out_valid;

    logic [CH_W-1:0]  chan_idx;
    logic [AW-1:0]    addr;
    logic             active;

    logic signed [mbq_pkg::COEF_W-1:0] m_coef;
    logic signed [SB-1:0]              m_val;
    logic signed [mbq_pkg::PROD_W-1:0] m_prod, m_rnd;

    logic [2*DW-1:0]                   rd_data, wr_data;
    logic signed [DW-1:0]              z1, z2, z2n;
    logic signed [mbq_pkg::YSUM_W-1:0] ysum;
    logic signed [mbq_pkg::YS_W-1:0]   ys;

    assign chan_idx = r_chan[CH_W-1:0];
    assign addr     = AW'(int'(chan_idx) * mbq_pkg::STAGES + int'(i_cmd.stage));
    assign active   = (CMP_W'(r_chan) < CMP_W'(r_count)) && (CMP_W'(r_chan) < CMP_W'(MAX_CHANNELS));

    always_comb begin
        clr_stages = '0;
        if (i_cfg_we) begin
            case (i_cfg_index)
                mbq_pkg::REG_ENABLE, mbq_pkg::REG_COUNT: clr_stages = '1;
                mbq_pkg::REG_HP_B, mbq_pkg::REG_HP_A:    clr_stages = 3'b001;
                mbq_pkg::REG_NOTCH_B, mbq_pkg::REG_NOTCH_A: clr_stages = 3'b010;
                mbq_pkg::REG_LP_B, mbq_pkg::REG_LP_A:    clr_stages = 3'b100;
                default: clr_stages = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= '0;
            r_count  <= 4'd8;
            for (int s = 0; s < mbq_pkg::STAGES; s++) begin
                r_coef_b[s] <= '0;
                r_coef_a[s] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mbq_pkg::REG_ENABLE:  r_enable <= i_cfg_data[mbq_pkg::STAGES-1:0];
                mbq_pkg::REG_COUNT:   r_count  <= i_cfg_data[3:0];
                mbq_pkg::REG_HP_B:    r_coef_b[mbq_pkg::ST_HP]    <= i_cfg_data;
                mbq_pkg::REG_HP_A:    r_coef_a[mbq_pkg::ST_HP]    <= i_cfg_data;
                mbq_pkg::REG_NOTCH_B: r_coef_b[mbq_pkg::ST_NOTCH] <= i_cfg_data;
                mbq_pkg::REG_NOTCH_A: r_coef_a[mbq_pkg::ST_NOTCH] <= i_cfg_data;
                mbq_pkg::REG_LP_B:    r_coef_b[mbq_pkg::ST_LP]    <= i_cfg_data;
                mbq_pkg::REG_LP_A:    r_coef_a[mbq_pkg::ST_LP]    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < MAX_CHANNELS; c++) begin
                r_valid[c] <= '0;
            end
        end else begin
            for (int c = 0; c < MAX_CHANNELS; c++) begin
                for (int s = 0; s < mbq_pkg::STAGES; s++) begin
                    if (clr_stages[s]) begin
                        r_valid[c][s] <= 1'b0;
                    end else if (i_cmd.op == mbq_pkg::OP_WRITE && int'(chan_idx) == c
                                 && int'(i_cmd.stage) == s) begin
                        r_valid[c][s] <= 1'b1;
                    end
                end
            end
        end
    end

    // shared multiplier: b0*x, b1*x, a1*y, a2*y in successive cycles
    always_comb begin
        case (i_cmd.op)
            mbq_pkg::OP_YCALC: begin
                m_coef = r_coef_b[i_cmd.stage][2*mbq_pkg::COEF_W-1:mbq_pkg::COEF_W];
                m_val  = r_x;
            end
            mbq_pkg::OP_A1: begin
                m_coef = r_coef_a[i_cmd.stage][mbq_pkg::COEF_W-1:0];
                m_val  = r_y;
            end
            mbq_pkg::OP_A2: begin
                m_coef = r_coef_a[i_cmd.stage][2*mbq_pkg::COEF_W-1:mbq_pkg::COEF_W];
                m_val  = r_y;
            end
            default: begin
                m_coef = r_coef_b[i_cmd.stage][mbq_pkg::COEF_W-1:0];
                m_val  = r_x;
            end
        endcase
        m_prod = m_coef * m_val;
        m_rnd  = m_prod + mbq_pkg::PROD_ROUND;
    end

    mbq_ram #(
        .WIDTH(2 * DW),
        .DEPTH(DEPTH)
    ) u_delay_ram (
        .i_clk  (i_clk),
        .i_we   (i_cmd.op == mbq_pkg::OP_WRITE),
        .i_waddr(addr),
        .i_wdata(wr_data),
        .i_re   (i_cmd.op == mbq_pkg::OP_READ),
        .i_raddr(addr),
        .o_rdata(rd_data)
    );

    assign z1 = r_vld ? $signed(rd_data[2*DW-1:DW]) : '0;
    assign z2 = r_vld ? $signed(rd_data[DW-1:0])    : '0;

    always_comb begin
        ysum = mbq_pkg::YSUM_W'(r_prod) + mbq_pkg::YSUM_W'(z1) + mbq_pkg::Y_ROUND;
        ys   = ysum[mbq_pkg::YSUM_W-1:mbq_pkg::Y_SHIFT];
        if (ys > mbq_pkg::Y_MAX) begin
            n_y   = mbq_pkg::Y_MAX[SB-1:0];
            y_sat = 1'b1;
        end else if (ys < mbq_pkg::Y_MIN) begin
            n_y   = mbq_pkg::Y_MIN[SB-1:0];
            y_sat = 1'b1;
        end else begin
            n_y   = ys[SB-1:0];
            y_sat = 1'b0;
        end
    end

    assign z2n     = mbq_pkg::sat_dly(mbq_pkg::DIFF_W'(r_pb0) - mbq_pkg::DIFF_W'(r_prod));
    assign wr_data = {r_z1n, z2n};

    always_ff @(posedge i_clk) begin
        if (i_in_accept) begin
            r_chan <= i_in_item.chan;
            r_x    <= i_in_item.sample_in;
            r_clip <= 1'b0;
        end
        case (i_cmd.op)
            mbq_pkg::OP_READ: begin
                r_vld  <= r_valid[chan_idx][i_cmd.stage];
                r_prod <= m_rnd[mbq_pkg::PROD_W-1:mbq_pkg::PROD_SHIFT];
            end
            mbq_pkg::OP_YCALC: begin
                r_y    <= n_y;
                r_clip <= r_clip | y_sat;
                r_pb0  <= r_prod;
                r_prod <= m_rnd[mbq_pkg::PROD_W-1:mbq_pkg::PROD_SHIFT];
            end
            mbq_pkg::OP_A1: begin
                r_acc  <= mbq_pkg::ACC_W'(r_prod) + mbq_pkg::ACC_W'(z2);
                r_prod <= m_rnd[mbq_pkg::PROD_W-1:mbq_pkg::PROD_SHIFT];
            end
            mbq_pkg::OP_A2: begin
                r_z1n  <= mbq_pkg::sat_dly(mbq_pkg::DIFF_W'(r_acc) - mbq_pkg::DIFF_W'(r_prod));
                r_prod <= m_rnd[mbq_pkg::PROD_W-1:mbq_pkg::PROD_SHIFT];
            end
            mbq_pkg::OP_WRITE: begin
                r_x <= r_y;
            end
            mbq_pkg::OP_EMIT: begin
                r_out.chan_out   <= r_chan;
                r_out.sample_out <= r_x;
                r_out.clipped    <= r_clip;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == mbq_pkg::OP_EMIT) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.active   = active;
    assign o_status.enable   = r_enable;
    assign o_status.out_busy = r_out_valid & i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
endmodule

// ----- design/multichannel_biquad_cascade.sv -----
// Channel  Direction  Handshake           Payload
// in       input      i_in_valid/o_in_stall   i_in_data  (t_in_item)
// out      output     o_out_valid/i_out_stall o_out_data (t_out_item)
// cfg      input      i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// A sample visits each enabled section in turn, HP, notch and LP, and skips them all
// when no section is on or the channel is inactive: one shared multiplier does the
// four products of a section on consecutive cycles, the first beside the delay RAM
// read and the last before the write-back. The next sample is taken once the result
// sits in the output register. Reset clears configuration and the delay valid bits,
// so no clearing pass is needed. A stalled output holds the sequencer before loading.
module multichannel_biquad_cascade #(
    parameter int MAX_CHANNELS = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  mbq_pkg::t_in_item                 i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output mbq_pkg::t_out_item                o_out_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [mbq_pkg::REG_IDX_W-1:0]     i_cfg_index,
    input  logic [mbq_pkg::CFG_W-1:0]         i_cfg_data
);
    mbq_pkg::t_cmd    cmd;
    mbq_pkg::t_status status;
    logic             in_accept;
    logic             cfg_we;

    assign o_in_stall  = !cmd.idle;
    assign o_cfg_ready = cmd.idle;
    assign in_accept   = i_in_valid & cmd.idle;
    assign cfg_we      = i_cfg_valid & cmd.idle;

    mbq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_accept(in_accept),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    mbq_dp #(
        .MAX_CHANNELS(MAX_CHANNELS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_in_accept(in_accept),
        .i_in_item  (i_in_data),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item (o_out_data)
    );
endmodule

// ----- sim/multichannel_biquad_cascade_tb.sv -----
module multichannel_biquad_cascade_tb;

    localparam int N_CHAN         = 8;
    localparam int N_SEC          = N_CHAN * mbq_pkg::STAGES;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RAND_PHASES    = 12;
    localparam int PHASE_ITEMS    = 128;

    localparam logic signed [mbq_pkg::SAMPLE_BITS-1:0] S_MAX =
        {1'b0, {(mbq_pkg::SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [mbq_pkg::SAMPLE_BITS-1:0] S_MIN =
        {1'b1, {(mbq_pkg::SAMPLE_BITS-1){1'b0}}};

    localparam longint DLY_MAX = (64'sd1 <<< (mbq_pkg::DLY_W - 1)) - 1;
    localparam longint DLY_MIN = -DLY_MAX - 1;
    localparam longint OUT_MAX = (64'sd1 <<< (mbq_pkg::SAMPLE_BITS - 1)) - 1;
    localparam longint OUT_MIN = -OUT_MAX - 1;

    // stable, well-behaved sections: {b1, b0} and {a2, a1}, Q2.30
    localparam logic [mbq_pkg::CFG_W-1:0] GENTLE [6] = '{
        {32'hC000_0000, 32'h2000_0000}, {32'h2000_0000, 32'hC000_0000},
        {32'h0000_0000, 32'h4000_0000}, {32'h2000_0000, 32'h0000_0000},
        {32'h1000_0000, 32'h0800_0000}, {32'h0800_0000, 32'hE000_0000}
    };
    localparam logic [mbq_pkg::CFG_W-1:0] EXTREME [4] = '{
        64'h7FFF_FFFF_7FFF_FFFF, 64'h8000_0000_8000_0000,
        64'h8000_0000_7FFF_FFFF, 64'h0000_0000_0000_0000
    };

    class filter_scoreboard;
        logic [mbq_pkg::STAGES-1:0]       enable_mask;
        logic [3:0]                       chan_count;
        logic [mbq_pkg::CFG_W-1:0]        b_coefs [mbq_pkg::STAGES];
        logic [mbq_pkg::CFG_W-1:0]        a_coefs [mbq_pkg::STAGES];
        logic signed [mbq_pkg::DLY_W-1:0] z_one [N_SEC];
        logic signed [mbq_pkg::DLY_W-1:0] z_two [N_SEC];
        mbq_pkg::t_out_item               expected_samples [$];
        int                               mismatch_count;

        function new();
            enable_mask    = '0;
            chan_count     = 4'd8;
            mismatch_count = 0;
            for (int s = 0; s < mbq_pkg::STAGES; s++) begin
                b_coefs[s] = '0;
                a_coefs[s] = '0;
                clear_section(s);
            end
        endfunction

        function void clear_section(int s);
            for (int ch = 0; ch < N_CHAN; ch++) begin
                z_one[ch * mbq_pkg::STAGES + s] = '0;
                z_two[ch * mbq_pkg::STAGES + s] = '0;
            end
        endfunction

        function void write_reg(logic [mbq_pkg::REG_IDX_W-1:0] idx,
                                logic [mbq_pkg::CFG_W-1:0] val);
            int s;
            case (idx)
                mbq_pkg::REG_ENABLE: begin
                    enable_mask = val[mbq_pkg::STAGES-1:0];
                    for (s = 0; s < mbq_pkg::STAGES; s++) clear_section(s);
                end
                mbq_pkg::REG_COUNT: begin
                    chan_count = val[3:0];
                    for (s = 0; s < mbq_pkg::STAGES; s++) clear_section(s);
                end
                mbq_pkg::REG_HP_B, mbq_pkg::REG_NOTCH_B, mbq_pkg::REG_LP_B: begin
                    s = (idx - mbq_pkg::REG_HP_B) / 2;
                    b_coefs[s] = val;
                    clear_section(s);
                end
                default: begin
                    s = (idx - mbq_pkg::REG_HP_A) / 2;
                    a_coefs[s] = val;
                    clear_section(s);
                end
            endcase
        endfunction

        // c * v rounded to 16 fraction bits
        function longint q16_product(longint c, longint v);
            return (c * v + 64'sd8192) >>> mbq_pkg::PROD_SHIFT;
        endfunction

        function longint sat_delay(longint v);
            if (v > DLY_MAX) return DLY_MAX;
            if (v < DLY_MIN) return DLY_MIN;
            return v;
        endfunction

        function longint run_section(int s, int slot, longint x, inout bit clip);
            longint b0, b1, a1, a2, pb0, y;
            b0  = $signed(b_coefs[s][31:0]);
            b1  = $signed(b_coefs[s][63:32]);
            a1  = $signed(a_coefs[s][31:0]);
            a2  = $signed(a_coefs[s][63:32]);
            pb0 = q16_product(b0, x);
            y   = (pb0 + longint'(z_one[slot]) + 64'sd32768) >>> mbq_pkg::Y_SHIFT;
            if (y > OUT_MAX) begin
                y    = OUT_MAX;
                clip = 1'b1;
            end else if (y < OUT_MIN) begin
                y    = OUT_MIN;
                clip = 1'b1;
            end
            z_one[slot] = sat_delay(q16_product(b1, x) - q16_product(a1, y)
                                    + longint'(z_two[slot]));
            z_two[slot] = sat_delay(pb0 - q16_product(a2, y));
            return y;
        endfunction

        function void predict_sample(mbq_pkg::t_in_item item);
            longint             y;
            bit                 clip;
            mbq_pkg::t_out_item res;
            y    = {{(64-mbq_pkg::SAMPLE_BITS){item.sample_in[mbq_pkg::SAMPLE_BITS-1]}},
                    item.sample_in};
            clip = 1'b0;
            if (item.chan < chan_count && item.chan < N_CHAN) begin
                for (int s = 0; s < mbq_pkg::STAGES; s++) begin
                    if (enable_mask[s])
                        y = run_section(s, item.chan * mbq_pkg::STAGES + s, y, clip);
                end
            end
            res.chan_out   = item.chan;
            res.sample_out = y[mbq_pkg::SAMPLE_BITS-1:0];
            res.clipped    = clip;
            expected_samples.push_back(res);
        endfunction

        function void check_sample(mbq_pkg::t_out_item got);
            mbq_pkg::t_out_item want;
            if (expected_samples.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: unexpected result chan %0d sample %0d clipped %0b",
                             $realtime, got.chan_out, got.sample_out, got.clipped);
                return;
            end
            want = expected_samples.pop_front();
            if (got.chan_out !== want.chan_out || got.sample_out !== want.sample_out ||
                got.clipped !== want.clipped) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: mismatch exp chan %0d sample %0d clip %0b, got %0d %0d %0b",
                             $realtime, want.chan_out, want.sample_out, want.clipped,
                             got.chan_out, got.sample_out, got.clipped);
            end
        endfunction

        function int pending();
            return expected_samples.size();
        endfunction
    endclass

    logic                              i_clk       = 1'b0;
    logic                              i_rst_n     = 1'b0;
    logic                              i_in_valid  = 1'b0;
    mbq_pkg::t_in_item                 i_in_data   = '0;
    logic                              i_out_stall = 1'b0;
    logic                              i_cfg_valid = 1'b0;
    logic [mbq_pkg::REG_IDX_W-1:0]     i_cfg_index = '0;
    logic [mbq_pkg::CFG_W-1:0]         i_cfg_data  = '0;
    logic                              o_in_stall;
    logic                              o_out_valid;
    mbq_pkg::t_out_item                o_out_data;
    logic                              o_cfg_ready;

    filter_scoreboard filt_sb = new();

    multichannel_biquad_cascade #(.MAX_CHANNELS(N_CHAN)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) filt_sb.check_sample(o_out_data);
    end

    // receiver stall pattern, changes mode after each random span
    initial begin
        int mode;
        int span;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(50, 300);
            while (span > 0) begin
                @(negedge i_clk);
                case (mode)
                    0: i_out_stall <= 1'b0;
                    1: i_out_stall <= $urandom_range(0, 1);
                    2: i_out_stall <= ($urandom_range(0, 7) != 0);
                    default: i_out_stall <= (span % 3 == 0);
                endcase
                span--;
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL multichannel_biquad_cascade");
        $finish;
    end

    task automatic send_sample(logic [mbq_pkg::CHAN_W-1:0] chan,
                               logic [mbq_pkg::SAMPLE_BITS-1:0] sample);
        mbq_pkg::t_in_item item;
        item.chan      = chan;
        item.sample_in = sample;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        forever begin
            @(posedge i_clk);
            if (!o_in_stall) break;
        end
        filt_sb.predict_sample(item);
    endtask

    task automatic hold_off(int cycles);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        i_in_data  <= mbq_pkg::t_in_item'($urandom);
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    // stop sending and let every outstanding transaction come back
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (filt_sb.pending() > 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [mbq_pkg::REG_IDX_W-1:0] idx,
                             logic [mbq_pkg::CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        filt_sb.write_reg(idx, val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [mbq_pkg::CFG_W-1:0] pick_coefs(int mode, int slot);
        int lo;
        int hi;
        case (mode)
            0: return GENTLE[slot];
            1: return {$urandom, $urandom};
            2: begin
                lo = $signed($urandom) >>> 1;
                hi = $signed($urandom) >>> 1;
                return {hi, lo};
            end
            default: return EXTREME[$urandom_range(0, 3)];
        endcase
    endfunction

    task automatic configure(logic [mbq_pkg::STAGES-1:0] mask, logic [3:0] count,
                             int coef_mode);
        cfg_write(mbq_pkg::REG_HP_B,    pick_coefs(coef_mode, 0));
        cfg_write(mbq_pkg::REG_HP_A,    pick_coefs(coef_mode, 1));
        cfg_write(mbq_pkg::REG_NOTCH_B, pick_coefs(coef_mode, 2));
        cfg_write(mbq_pkg::REG_NOTCH_A, pick_coefs(coef_mode, 3));
        cfg_write(mbq_pkg::REG_LP_B,    pick_coefs(coef_mode, 4));
        cfg_write(mbq_pkg::REG_LP_A,    pick_coefs(coef_mode, 5));
        cfg_write(mbq_pkg::REG_COUNT,   mbq_pkg::CFG_W'(count));
        cfg_write(mbq_pkg::REG_ENABLE,  mbq_pkg::CFG_W'(mask));
    endtask

    function automatic logic [mbq_pkg::SAMPLE_BITS-1:0] rand_sample();
        int k;
        k = $urandom_range(0, 9);
        if (k < 5) return mbq_pkg::SAMPLE_BITS'($urandom);
        if (k < 8)
            return mbq_pkg::SAMPLE_BITS'($signed($urandom_range(0, 8191)) - 4096);
        return (k == 8) ? S_MAX : S_MIN;
    endfunction

    initial begin
        int                          counts [RAND_PHASES];
        logic [3:0]                  count;
        logic [2:0]                  mask;
        int                          burst_left;
        int                          gap;
        bit                          no_gaps;
        logic [mbq_pkg::CHAN_W-1:0]  chan;

        counts = '{8, 3, 0, 8, 1, 5, 8, 7, 2, 8, 6, 4};
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset configuration: everything passes straight through
        send_sample(0, S_MAX);
        send_sample(0, S_MIN);
        send_sample(63, '1);
        send_sample(8, 1);
        send_sample(5, 24'h555555);
        drain();

        configure(3'b111, 4'd8, 0);
        send_sample(0, S_MAX);
        send_sample(0, S_MIN);
        send_sample(0, S_MAX);
        send_sample(7, S_MIN);
        send_sample(7, '1);
        send_sample(8, 100);
        send_sample(63, S_MAX);
        send_sample(2, 1000);
        send_sample(2, 1000);
        drain();
        // each of these writes wipes delay state, the LP_A write only that of the LP section
        cfg_write(mbq_pkg::REG_ENABLE, 64'd7);
        send_sample(2, 1000);
        drain();
        cfg_write(mbq_pkg::REG_LP_A, GENTLE[5]);
        send_sample(2, 1000);
        drain();
        cfg_write(mbq_pkg::REG_COUNT, 64'd8);
        send_sample(2, 1000);
        drain();
        cfg_write(mbq_pkg::REG_COUNT, 64'd2);
        send_sample(2, 500);
        send_sample(1, 500);
        drain();
        cfg_write(mbq_pkg::REG_COUNT, 64'd8);
        cfg_write(mbq_pkg::REG_ENABLE, 64'd0);
        send_sample(3, S_MAX);
        send_sample(4, S_MIN);
        drain();

        for (int p = 0; p < RAND_PHASES; p++) begin
            mask  = 3'((p * 5 + 7) % 8);
            count = 4'(counts[p]);
            configure(mask, count, p % 4);
            burst_left = 0;
            no_gaps    = (p % 5 == 4);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == PHASE_ITEMS / 2) drain();
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    if ($urandom_range(0, 15) == 0) gap = 40;
                    if (!no_gaps && gap > 0) hold_off(gap);
                end
                if (count != 0 && $urandom_range(0, 3) != 0)
                    chan = mbq_pkg::CHAN_W'($urandom_range(0, count - 1));
                else
                    chan = mbq_pkg::CHAN_W'($urandom);
                send_sample(chan, rand_sample());
                burst_left--;
            end
            drain();
        end

        repeat (30) @(posedge i_clk);
        filt_sb.mismatch_count += filt_sb.pending();
        if (filt_sb.mismatch_count == 0)
            $display("PASS multichannel_biquad_cascade");
        else
            $display("FAIL multichannel_biquad_cascade");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/mbq_pkg.sv
design/mbq_ram.sv
design/mbq_ctrl.sv
design/mbq_dp.sv
design/multichannel_biquad_cascade.sv
sim/multichannel_biquad_cascade_tb.sv
